// ===== hw/rtl/ict_pkg.sv =====
// Package for the interval constraint table.
// Holds item types, codes, the sequencer state type and the compare unit flags.
// No dependencies.
package ict_pkg;

	localparam int TIME_W = 16;
	localparam int LOC_W  = 10;

	typedef logic [1:0] status_t;
	localparam status_t STS_OK    = 2'd0;
	localparam status_t STS_FULL  = 2'd1;
	localparam status_t STS_EMPTY = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic CFG_GOAL    = 1'b0;
	localparam logic CFG_MIN_LEN = 1'b1;

	typedef struct packed {
		logic              action;
		logic [LOC_W-1:0]  location;
		logic [TIME_W-1:0] time_start;
		logic [TIME_W-1:0] time_end;
	} in_item_t;

	typedef struct packed {
		logic              is_blocked;
		logic [TIME_W-1:0] holding_time;
		logic [TIME_W-1:0] temporal_extent;
		status_t           status;
	} out_item_t;

	// Flags of the shared compare unit for one stored interval.
	typedef struct packed {
		logic end_lt_s;    // stored end before new start
		logic e_lt_start;  // new end before stored start
		logic start_lt_s;  // stored start extends merge left
		logic end_gt_e;    // stored end extends merge right
		logic hit;         // query time inside stored interval
		logic end_gt_h;    // stored end raises holding time
	} cmp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RED,
		ST_CNT_RD,
		ST_CNT_WT,
		ST_RD,
		ST_EVAL,
		ST_PUSH2,
		ST_LAST,
		ST_WB_RD,
		ST_WB_WR,
		ST_CNT_WR,
		ST_G_CNT_RD,
		ST_G_CNT_WT,
		ST_G_RD,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/ict_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module ict_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end
endmodule

// ===== hw/rtl/ict_alu.sv =====
// Shared compare unit applied to one stored interval per step of the walk.
// Depends on ict_pkg.
module ict_alu (
	input  logic [15:0]   cur_start,
	input  logic [15:0]   cur_end,
	input  logic [15:0]   new_start,
	input  logic [15:0]   new_end,
	input  logic [15:0]   hold,
	output ict_pkg::cmp_t flags
);
	import ict_pkg::*;

	always_comb begin
		flags.end_lt_s   = cur_end < new_start;
		flags.e_lt_start = new_end < cur_start;
		flags.start_lt_s = cur_start < new_start;
		flags.end_gt_e   = cur_end > new_end;
		flags.hit        = (cur_start <= new_start) && (new_start < cur_end);
		flags.end_gt_h   = cur_end > hold;
	end
endmodule

// ===== hw/rtl/interval_constraint_table.sv =====
// Top level of the interval constraint table: sequencer, registers and memories.
// Depends on ict_pkg, ict_ram and ict_alu.
//
// Usage: an item arrives on in_valid/in_ready with in_data. An insert merges
// [time_start,time_end) into the sorted list of its location; a query checks
// whether time_start lies in a stored interval. Each item yields one result
// item on out_valid/out_ready with out_data, which also carries the holding
// time at the goal location and the temporal extent. Registers are written on
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
//
// Throughput: one item at a time; in_ready is low from acceptance until the
// result item is taken. An item walks the list of its location and then,
// when a goal is set, the goal list. An insert also writes back the merged
// list; an insert rejected as full skips that write-back, and an empty
// interval skips its own walk. Both walks use the single memory port of the
// interval store, which reads one interval in each read state for the
// evaluate state that follows. The next item can be taken in the cycle after
// the result item. When NUM_LOCATIONS is below 1024 the location and goal
// are first reduced modulo the table size by ten compare and subtract steps,
// one per cycle.
// After reset a clearing pass zeroes the count memory with in_ready low. A
// stalled receiver simply holds the result item; the block waits in its output
// state and takes no new item until it is taken.
module interval_constraint_table #(
	parameter int          NUM_LOCATIONS          = 1024,
	parameter int          INTERVALS_PER_LOCATION = 8,
	parameter logic [31:0] FOREVER_TIME           = 32'd65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ict_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ict_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import ict_pkg::*;

	localparam int IPL   = INTERVALS_PER_LOCATION;
	localparam int LW    = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
	localparam int AW    = $clog2(NUM_LOCATIONS * IPL);
	localparam int CW    = $clog2(IPL + 1);
	localparam int MW    = $clog2(IPL + 2);
	localparam int TAW   = $clog2(IPL + 1);
	localparam bit NEED_RED = NUM_LOCATIONS < 1024;

	state_t state_q, state_d;

	// Configuration registers.
	logic signed [10:0] goal_q;
	logic [15:0]        min_len_q;

	// Item and working registers.
	in_item_t         item_q;
	logic [9:0]       loc_q, goal_r_q;
	logic [3:0]       red_k_q;
	logic [LW-1:0]    clr_q;
	logic [AW-1:0]    base_q;
	logic [CW-1:0]    n_q, i_q;
	logic [MW-1:0]    m_q, j_q;
	logic [15:0]      s_q, e_q, h_q;
	logic             placed_q, blocked_q;
	logic             goal_walk_q;
	status_t          status_q;
	logic [31:0]      cur2_q;
	logic [15:0]      latest_q, extent_q;

	// Memory ports.
	logic             st_en, st_we;
	logic [AW-1:0]    st_addr;
	logic [31:0]      st_wdata, st_rdata;
	logic             cn_en, cn_we;
	logic [LW-1:0]    cn_addr;
	logic [CW-1:0]    cn_wdata, cn_rdata, cn_clamp;
	logic             tm_en, tm_we;
	logic [TAW-1:0]   tm_addr;
	logic [31:0]      tm_wdata, tm_rdata;

	cmp_t             flags;
	logic [15:0]      loc16, goal16;
	logic [LW-1:0]    loc_idx, goal_idx;
	logic [31:0]      loc_prod, goal_prod, red_d;
	logic [MW-1:0]    m_new;

	ict_ram #(.WIDTH(32), .DEPTH(NUM_LOCATIONS * IPL)) u_store (
		.clk(clk), .en(st_en), .we(st_we), .addr(st_addr),
		.wdata(st_wdata), .rdata(st_rdata)
	);

	ict_ram #(.WIDTH(CW), .DEPTH(NUM_LOCATIONS)) u_count (
		.clk(clk), .en(cn_en), .we(cn_we), .addr(cn_addr),
		.wdata(cn_wdata), .rdata(cn_rdata)
	);

	ict_ram #(.WIDTH(32), .DEPTH(IPL + 1)) u_merge_buf (
		.clk(clk), .en(tm_en), .we(tm_we), .addr(tm_addr),
		.wdata(tm_wdata), .rdata(tm_rdata)
	);

	ict_alu u_alu (
		.cur_start(st_rdata[15:0]),
		.cur_end  (st_rdata[31:16]),
		.new_start(item_q.action == ACT_QUERY ? item_q.time_start : s_q),
		.new_end  (e_q),
		.hold     (h_q),
		.flags    (flags)
	);

	assign loc16     = {6'b0, loc_q};
	assign goal16    = {6'b0, goal_r_q};
	assign loc_idx   = loc16[LW-1:0];
	assign goal_idx  = goal16[LW-1:0];
	assign loc_prod  = 32'(loc_idx) * 32'(IPL);
	assign goal_prod = 32'(goal_idx) * 32'(IPL);
	assign red_d     = 32'(NUM_LOCATIONS) << red_k_q;
	assign cn_clamp  = (cn_rdata > CW'(IPL)) ? CW'(IPL) : cn_rdata;
	assign m_new     = m_q + MW'(!placed_q);
	assign cfg_ready = 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == LW'(NUM_LOCATIONS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) state_d = NEED_RED ? ST_RED : ST_CNT_RD;
			end
			ST_RED: begin
				if (!NEED_RED || red_k_q == 4'd0) state_d = ST_CNT_RD;
			end
			ST_CNT_RD: begin
				if (item_q.action == ACT_INSERT && item_q.time_end <= item_q.time_start) begin
					state_d = ST_G_CNT_RD;
				end else begin
					state_d = ST_CNT_WT;
				end
			end
			ST_CNT_WT: state_d = ST_RD;
			ST_RD: begin
				if (i_q == n_q) begin
					state_d = (item_q.action == ACT_QUERY) ? ST_G_CNT_RD : ST_LAST;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (item_q.action == ACT_INSERT && !flags.end_lt_s && flags.e_lt_start
						&& !placed_q) begin
					state_d = ST_PUSH2;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_PUSH2: state_d = ST_RD;
			ST_LAST:  state_d = (m_new > MW'(IPL)) ? ST_G_CNT_RD : ST_WB_RD;
			ST_WB_RD: state_d = (j_q == m_q) ? ST_CNT_WR : ST_WB_WR;
			ST_WB_WR: state_d = ST_WB_RD;
			ST_CNT_WR: state_d = ST_G_CNT_RD;
			ST_G_CNT_RD: state_d = goal_q[10] ? ST_OUT : ST_G_CNT_WT;
			ST_G_CNT_WT: state_d = ST_G_RD;
			ST_G_RD: state_d = (i_q == n_q) ? ST_OUT : ST_EVAL;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// The goal walk reuses the evaluation state; it returns to its own read.
		if (state_q == ST_EVAL && goal_walk_q) state_d = ST_G_RD;
	end

	// Outputs and memory controls.
	always_comb begin
		in_ready  = state_q == ST_IDLE;
		out_valid = state_q == ST_OUT;
		out_data.is_blocked      = blocked_q;
		out_data.holding_time    = h_q;
		out_data.temporal_extent = extent_q;
		out_data.status          = status_q;
		st_en = 1'b0; st_we = 1'b0; st_addr = base_q + AW'(i_q); st_wdata = tm_rdata;
		cn_en = 1'b0; cn_we = 1'b0; cn_addr = loc_idx; cn_wdata = CW'(m_q);
		tm_en = 1'b0; tm_we = 1'b0; tm_addr = TAW'(m_q); tm_wdata = st_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				cn_en = 1'b1; cn_we = 1'b1; cn_addr = clr_q; cn_wdata = '0;
			end
			ST_CNT_RD: cn_en = 1'b1;
			ST_RD, ST_G_RD: st_en = i_q != n_q;
			ST_EVAL: begin
				if (item_q.action == ACT_INSERT && !goal_walk_q) begin
					if (flags.end_lt_s) begin
						tm_en = 1'b1; tm_we = 1'b1;
					end else if (flags.e_lt_start) begin
						tm_en = 1'b1; tm_we = 1'b1;
						if (!placed_q) tm_wdata = {e_q, s_q};
					end
				end
			end
			ST_PUSH2: begin
				tm_en = 1'b1; tm_we = 1'b1; tm_wdata = cur2_q;
			end
			ST_LAST: begin
				tm_en = !placed_q && m_q <= MW'(IPL); tm_we = 1'b1;
				tm_wdata = {e_q, s_q};
			end
			ST_WB_RD: begin
				tm_en = j_q != m_q; tm_addr = TAW'(j_q);
			end
			ST_WB_WR: begin
				st_en = 1'b1; st_we = 1'b1; st_addr = base_q + AW'(j_q);
			end
			ST_CNT_WR: begin
				cn_en = 1'b1; cn_we = 1'b1;
			end
			ST_G_CNT_RD: begin
				cn_en = !goal_q[10]; cn_addr = goal_idx;
			end
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q    <= -11'sd1;
			min_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_GOAL) goal_q <= signed'(cfg_data[10:0]);
			if (cfg_index == CFG_MIN_LEN) min_len_q <= cfg_data;
		end
	end

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			latest_q    <= '0;
			extent_q    <= '0;
			goal_walk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + LW'(1);
				ST_IDLE: begin
					item_q      <= in_data;
					loc_q       <= in_data.location;
					goal_r_q    <= goal_q[9:0];
					red_k_q     <= 4'd9;
					s_q         <= in_data.time_start;
					e_q         <= in_data.time_end;
					placed_q    <= 1'b0;
					blocked_q   <= 1'b0;
					goal_walk_q <= 1'b0;
					status_q    <= STS_OK;
					i_q         <= '0;
					m_q         <= '0;
					j_q         <= '0;
				end
				ST_RED: begin
					if ({22'b0, loc_q} >= red_d) loc_q <= loc_q - red_d[9:0];
					if ({22'b0, goal_r_q} >= red_d) goal_r_q <= goal_r_q - red_d[9:0];
					red_k_q <= red_k_q - 4'd1;
				end
				ST_CNT_RD: begin
					base_q <= loc_prod[AW-1:0];
					if (item_q.action == ACT_INSERT && item_q.time_end <= item_q.time_start) begin
						status_q <= STS_EMPTY;
					end
				end
				ST_CNT_WT: n_q <= cn_clamp;
				ST_EVAL: begin
					i_q <= i_q + CW'(1);
					if (goal_walk_q) begin
						if (flags.end_gt_h) h_q <= st_rdata[31:16];
					end else if (item_q.action == ACT_QUERY) begin
						if (flags.hit) blocked_q <= 1'b1;
					end else if (flags.end_lt_s) begin
						m_q <= m_q + MW'(1);
					end else if (flags.e_lt_start) begin
						m_q <= m_q + MW'(1);
						if (!placed_q) begin
							placed_q <= 1'b1;
							cur2_q   <= st_rdata;
						end
					end else begin
						if (flags.start_lt_s) s_q <= st_rdata[15:0];
						if (flags.end_gt_e) e_q <= st_rdata[31:16];
					end
				end
				ST_PUSH2: m_q <= m_q + MW'(1);
				ST_LAST: begin
					if (m_new > MW'(IPL)) begin
						status_q <= STS_FULL;
					end else begin
						m_q <= m_new;
					end
				end
				ST_WB_WR: j_q <= j_q + MW'(1);
				ST_CNT_WR: begin
					if ({16'b0, item_q.time_end} < FOREVER_TIME) begin
						if (item_q.time_end > latest_q) begin
							latest_q <= item_q.time_end;
							if (item_q.time_end > extent_q) extent_q <= item_q.time_end;
						end
					end else if ({16'b0, item_q.time_end} == FOREVER_TIME) begin
						if (item_q.time_start > latest_q) begin
							latest_q <= item_q.time_start;
							if (item_q.time_start > extent_q) extent_q <= item_q.time_start;
						end
					end
				end
				ST_G_CNT_RD: begin
					h_q         <= min_len_q;
					base_q      <= goal_prod[AW-1:0];
					goal_walk_q <= 1'b1;
				end
				ST_G_CNT_WT: begin
					n_q <= cn_clamp;
					i_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// A result never reports a blocked time together with a rejected insert.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STS_OK |-> !out_data.is_blocked)
		else $error("blocked flag set on a rejected insert");

	// Queries never report a status other than ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.action == ACT_QUERY |=> status_q == STS_OK)
		else $error("query started with a non-ok status");

	// No result is offered while a new item can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("result offered while accepting");

	// The extent never falls.
	assert property (@(posedge clk) disable iff (!arst_n)
		extent_q >= $past(extent_q))
		else $error("temporal extent decreased");

	// The status code is always a defined one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STS_OK || out_data.status == STS_FULL
			|| out_data.status == STS_EMPTY))
		else $error("undefined status code");
endmodule

// ===== tb/tb_interval_constraint_table.sv =====
// Self-checking testbench for the interval constraint table.
// Depends on ict_pkg and interval_constraint_table; a scoreboard class predicts each result.
module tb_interval_constraint_table;
	timeunit 1ns;
	timeprecision 1ps;
	import ict_pkg::*;

	localparam int NLOC  = 1024;
	localparam int IPL   = 8;
	localparam int FOREV = 65535;
	localparam int WDOG_LIMIT = 20000;

	// Scoreboard: its own copy of the table, predicting one result per item.
	class interval_scoreboard;
		logic [15:0] iv_start [NLOC][IPL];
		logic [15:0] iv_end   [NLOC][IPL];
		int          iv_count [NLOC];
		int unsigned latest, extent;
		int          goal;
		int unsigned min_len;
		out_item_t   pending [$];
		int          errors, checked, inserts, queries, rejects;

		function void clear_state();
			foreach (iv_count[i]) iv_count[i] = 0;
			latest = 0; extent = 0; goal = -1; min_len = 0;
			errors = 0; checked = 0; inserts = 0; queries = 0; rejects = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			logic [10:0] g;
			g = val[10:0];
			if (idx == CFG_GOAL) goal = int'($signed(g));
			else min_len = 32'(val);
		endfunction

		function int unsigned holding_now();
			int unsigned h;
			h = min_len;
			if (goal >= 0)
				for (int i = 0; i < iv_count[goal % NLOC]; i++)
					if (32'(iv_end[goal % NLOC][i]) > h) h = 32'(iv_end[goal % NLOC][i]);
			return h;
		endfunction

		// Merge [s,e) into the list; returns the status code.
		function status_t merge_interval(int loc, int unsigned ns, int unsigned ne);
			logic [15:0] ts [IPL+1], te [IPL+1];
			int m;
			int unsigned s, e, cs, ce;
			bit placed;
			m = 0; s = ns; e = ne; placed = 0;
			if (ne <= ns) return STS_EMPTY;
			for (int i = 0; i < iv_count[loc]; i++) begin
				cs = 32'(iv_start[loc][i]); ce = 32'(iv_end[loc][i]);
				if (ce < s) begin
					if (m > IPL) return STS_FULL;
					ts[m] = 16'(cs); te[m] = 16'(ce); m++;
				end else if (e < cs) begin
					if (!placed) begin
						if (m > IPL) return STS_FULL;
						ts[m] = 16'(s); te[m] = 16'(e); m++; placed = 1;
					end
					if (m > IPL) return STS_FULL;
					ts[m] = 16'(cs); te[m] = 16'(ce); m++;
				end else begin
					if (cs < s) s = cs;
					if (ce > e) e = ce;
				end
			end
			if (!placed) begin
				if (m > IPL) return STS_FULL;
				ts[m] = 16'(s); te[m] = 16'(e); m++;
			end
			if (m > IPL) return STS_FULL;
			for (int i = 0; i < m; i++) begin
				iv_start[loc][i] = ts[i]; iv_end[loc][i] = te[i];
			end
			iv_count[loc] = m;
			if (ne < FOREV && ne > latest) latest = ne;
			else if (ne == FOREV && ns > latest) latest = ns;
			if (latest > extent) extent = latest;
			return STS_OK;
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			r = '0;
			if (it.action == ACT_INSERT) begin
				r.status = merge_interval(int'(it.location), 32'(it.time_start),
					32'(it.time_end));
				inserts++;
				if (r.status != STS_OK) rejects++;
			end else begin
				queries++;
				for (int i = 0; i < iv_count[it.location]; i++)
					if (iv_start[it.location][i] <= it.time_start &&
					    it.time_start < iv_end[it.location][i]) r.is_blocked = 1;
			end
			r.holding_time = 16'(holding_now());
			r.temporal_extent = 16'(extent);
			pending = {pending, r};
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("mismatch on result %0d: %s got %0d expected %0d",
				checked, what, got, want);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.is_blocked != want.is_blocked)
				report_mismatch("is_blocked", int'(got.is_blocked), int'(want.is_blocked));
			if (got.holding_time != want.holding_time)
				report_mismatch("holding_time", int'(got.holding_time),
					int'(want.holding_time));
			if (got.temporal_extent != want.temporal_extent)
				report_mismatch("temporal_extent", int'(got.temporal_extent),
					int'(want.temporal_extent));
			if (got.status != want.status)
				report_mismatch("status", int'(got.status), int'(want.status));
			checked++;
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;
	in_item_t  in_data;
	out_item_t out_data;

	interval_constraint_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	interval_scoreboard sb;
	int  idle_cycles;
	bit  quiet_mode;     // no idling on either side near the end
	bit  hold_sink;      // long receiver stall requested by the stimulus
	bit  hold_done = 0;  // the receiver has served the long stall
	int  hot_locs [4];   // small set of locations so lists fill and merge

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink && !hold_done) begin
				hold_done = 1;
				out_ready <= 0;
				repeat (300) @(negedge clk);
			end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	// Results are checked at the rising edge when they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Watchdog: cycles without any accepted item or taken result.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("timeout with %0d results outstanding", sb.pending.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// Offers one item and waits for it to be accepted; the payload is noted
	// in the scoreboard at the accepting edge, before the result can appear.
	// Valid drops only when an idle burst follows, so the next item can be
	// offered at the same falling edge.
	task automatic send_item(logic act, int loc, int ts, int te);
		in_item_t it;
		it.action = act; it.location = 10'(loc);
		it.time_start = 16'(ts); it.time_end = 16'(te);
		in_valid <= 1; in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		@(negedge clk);
		if (!quiet_mode && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// One random item: mostly well-formed inserts and queries on a few hot
	// locations, with some wide-range noise and empty intervals.
	task automatic random_item();
		int loc, ts, len, kind;
		kind = $urandom_range(0, 99);
		loc = (kind < 80) ? hot_locs[$urandom_range(0, 3)] : $urandom_range(0, NLOC-1);
		ts = $urandom_range(0, 65535);
		if (kind < 45) begin
			ts = $urandom_range(0, 400);
			len = $urandom_range(1, 30);
			send_item(ACT_INSERT, loc, ts, ($urandom_range(0, 19) == 0) ? FOREV : ts + len);
		end else if (kind < 50)
			send_item(ACT_INSERT, loc, ts, $urandom_range(0, ts));
		else if (kind < 55)
			send_item(ACT_INSERT, loc, ts, $urandom_range(0, 65535));
		else if (kind < 90)
			send_item(ACT_QUERY, loc, $urandom_range(0, 430), $urandom_range(0, 65535));
		else
			send_item(ACT_QUERY, loc, ts, $urandom_range(0, 65535));
	endtask

	task automatic new_hot_set();
		foreach (hot_locs[i]) hot_locs[i] = $urandom_range(0, NLOC-1);
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		quiet_mode = 0; hold_sink = 0;
		in_valid = 0; in_data = '0;
		cfg_valid = 0; cfg_index = CFG_GOAL; cfg_data = '0;
		arst_n = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: goal at location 5, then extremes and special cases.
		write_reg(CFG_GOAL, 16'd5);
		write_reg(CFG_MIN_LEN, 16'd0);
		send_item(ACT_QUERY, 5, 0, 0);             // empty list
		send_item(ACT_INSERT, 5, 10, 20);
		send_item(ACT_INSERT, 5, 30, 40);
		send_item(ACT_INSERT, 5, 20, 30);          // touches both neighbors
		send_item(ACT_QUERY, 5, 39, 0);
		send_item(ACT_QUERY, 5, 40, 0);            // end is exclusive
		send_item(ACT_INSERT, 5, 50, 50);          // empty interval
		send_item(ACT_INSERT, 5, 65535, 0);        // end before start
		for (int i = 0; i < 8; i++)                // fill, then overflow
			send_item(ACT_INSERT, 1023, 100 + 4*i, 102 + 4*i);
		send_item(ACT_INSERT, 1023, 0, 1);
		send_item(ACT_INSERT, 1023, 200, 201);
		send_item(ACT_INSERT, 1023, 101, 129);     // merges into fewer
		send_item(ACT_INSERT, 0, 0, 65535);        // forever interval
		send_item(ACT_INSERT, 5, 65534, 65535);
		send_item(ACT_QUERY, 0, 65535, 65535);
		send_item(ACT_QUERY, 1023, 65535, 65535);
		wait_drained();

		// Random phases across several register settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			new_hot_set();
			case (ph)
				0: begin write_reg(CFG_GOAL, 16'h07FF); write_reg(CFG_MIN_LEN, 16'hFFFF); end
				1: begin write_reg(CFG_GOAL, 16'(hot_locs[0])); write_reg(CFG_MIN_LEN, 16'd0); end
				2: begin write_reg(CFG_GOAL, 16'd1023); write_reg(CFG_MIN_LEN, 16'd150); end
				3: begin write_reg(CFG_GOAL, 16'h0400); write_reg(CFG_MIN_LEN, 16'd20); end
				default: begin
					write_reg(CFG_GOAL, 16'(hot_locs[1]));
					write_reg(CFG_MIN_LEN, 16'($urandom_range(0, 65535)));
				end
			endcase
			if (ph == 2) hold_sink = 1;    // long receiver stall while offering
			if (ph == 5) quiet_mode = 1;   // final stretch without idling
			for (int n = 0; n < 170; n++) begin
				random_item();
				if (ph == 3 && n == 80) wait_drained();
			end
			wait_drained();
		end

		$display("covered %0d inserts (%0d rejected) and %0d queries under 7 register settings,",
			sb.inserts, sb.rejects, sb.queries);
		$display("with a long receiver stall, random idling and drained pauses");
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
